/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk with rst_n low as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LTRI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LTRI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ltri_pkg.sv */
// ----------------------------------------------------------------------------
// ltri_pkg
// Shared constants of the three-line triangle area core.
// ----------------------------------------------------------------------------
package ltri_pkg;

  // default configuration
  localparam int COEF_WIDTH      = 12;
  localparam int POINT_FRAC_BITS = 16;
  localparam int AREA_FRAC_BITS  = 8;

  // fixed result field widths
  localparam int PNT_W  = 41;
  localparam int AREA_W = 56;

endpackage

/* rtl/ltri_in_if.sv */
// ----------------------------------------------------------------------------
// ltri_in_if
// Input channel: one word carries three lines a*x + b*y = c.
// ----------------------------------------------------------------------------
interface ltri_in_if #(
  parameter int COEF_W = ltri_pkg::COEF_WIDTH
) ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] line1_a;
  logic signed [COEF_W-1:0] line1_b;
  logic signed [COEF_W-1:0] line1_c;
  logic signed [COEF_W-1:0] line2_a;
  logic signed [COEF_W-1:0] line2_b;
  logic signed [COEF_W-1:0] line2_c;
  logic signed [COEF_W-1:0] line3_a;
  logic signed [COEF_W-1:0] line3_b;
  logic signed [COEF_W-1:0] line3_c;

  modport source (
    output valid, line1_a, line1_b, line1_c, line2_a, line2_b, line2_c,
           line3_a, line3_b, line3_c,
    input  ready
  );
  modport sink (
    input  valid, line1_a, line1_b, line1_c, line2_a, line2_b, line2_c,
           line3_a, line3_b, line3_c,
    output ready
  );
endinterface

/* rtl/ltri_out_if.sv */
// ----------------------------------------------------------------------------
// ltri_out_if
// Result channel: flags, three vertices and the area of one triangle.
// ----------------------------------------------------------------------------
interface ltri_out_if ();
  logic                             valid;
  logic                             ready;
  logic                             is_triangle;
  logic                             parallel_12;
  logic                             parallel_13;
  logic                             parallel_23;
  logic signed [ltri_pkg::PNT_W-1:0] p12_x;
  logic signed [ltri_pkg::PNT_W-1:0] p12_y;
  logic signed [ltri_pkg::PNT_W-1:0] p13_x;
  logic signed [ltri_pkg::PNT_W-1:0] p13_y;
  logic signed [ltri_pkg::PNT_W-1:0] p23_x;
  logic signed [ltri_pkg::PNT_W-1:0] p23_y;
  logic [ltri_pkg::AREA_W-1:0]        tri_area;

  modport source (
    output valid, is_triangle, parallel_12, parallel_13, parallel_23,
           p12_x, p12_y, p13_x, p13_y, p23_x, p23_y, tri_area,
    input  ready
  );
  modport sink (
    input  valid, is_triangle, parallel_12, parallel_13, parallel_23,
           p12_x, p12_y, p13_x, p13_y, p23_x, p23_y, tri_area,
    output ready
  );
endinterface

/* rtl/ltri_div.sv */
// ----------------------------------------------------------------------------
// ltri_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ltri_div #(
  parameter int DEN_W  = 25,
  parameter int QUO_W  = 41,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [QUO_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DEN_W-1:0]  rem_r  [QUO_W];
  logic [QUO_W-1:0]  num_r  [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0]  rem_in;
    logic [QUO_W-1:0]  num_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W+1:0]  trial;
    logic [DEN_W-1:0]  rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign num_in  = num_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial   = {1'b0, rem_in, num_in[QUO_W-1]} - {2'b00, den_in};
    assign rem_nxt = trial[DEN_W+1] ? {rem_in[DEN_W-2:0], num_in[QUO_W-1]}
                                    : trial[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        num_r[k]  <= num_in << 1;
        den_r[k]  <= den_in;
        quo_r[k]  <= {quo_in[QUO_W-2:0], ~trial[DEN_W+1]};
        side_r[k] <= side_in;
      end
    end
  end

  assign quo_o  = quo_r[QUO_W-1];
  assign side_o = side_r[QUO_W-1];

endmodule

/* rtl/three_line_triangle_area_core.sv */
// ----------------------------------------------------------------------------
// three_line_triangle_area_core
// Triangle vertices and area from three lines, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word of three lines a*x + b*y = c; a word is taken
//   at a clock edge with valid and ready both high. out_ch returns one
//   word per input word, in order: triangle and parallel flags, the three
//   vertices in Q24.16 and the area in Q48.8, saturating.
//   Throughput is one word per cycle while out_ch is not stalled. The area
//   divider, which resolves one quotient bit per stage, sets the pipeline
//   depth; the vertex dividers are shorter and their results wait in a
//   delay line.
//   A stall on out_ch freezes the whole pipeline; in_ch.ready stays high
//   while the output register is empty or being taken, so a new word is
//   accepted in the same cycle that a finished one leaves.
//   Synchronous reset clears all valid bits and holds in_ch.ready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_line_triangle_area_core #(
  parameter int COEF_WIDTH      = ltri_pkg::COEF_WIDTH,
  parameter int POINT_FRAC_BITS = ltri_pkg::POINT_FRAC_BITS,
  parameter int AREA_FRAC_BITS  = ltri_pkg::AREA_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  ltri_in_if.sink     in_ch,
  ltri_out_if.source  out_ch
);

  localparam int W      = COEF_WIDTH;
  localparam int PF     = POINT_FRAC_BITS;
  localparam int AF     = AREA_FRAC_BITS;
  localparam int PNT_W  = ltri_pkg::PNT_W;
  localparam int AREA_W = ltri_pkg::AREA_W;
  localparam int DW     = 2 * W + 1;          // determinants, numerators
  localparam int MW     = 2 * W;              // their magnitudes
  localparam int TW     = 3 * W + 1;          // triple products
  localparam int D3W    = 3 * W + 2;          // 3x3 determinant
  localparam int M3W    = 3 * W;              // its magnitude
  localparam int H      = (M3W + 1) / 2;      // split of the square
  localparam int HW     = M3W - H;
  localparam int PABW   = 4 * W;
  localparam int NUMW   = 6 * W + AF + 1;     // area numerator
  localparam int DENA_W = 6 * W;              // area denominator
  localparam int QA     = AREA_W + 1;         // area quotient bits
  localparam int NUMX   = NUMW + QA;
  localparam int QP     = 2 * W + PF + 1;     // point quotient bits
  localparam int PDW    = 2 * W + 1;          // point denominator
  localparam int L      = 4 + QA - QP;        // point delay line depth
  localparam int NV     = 6 + QA;             // valid bits before output
  localparam int SA     = 5;                  // area sideband width

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  function automatic logic signed [DW-1:0] det2(
    input logic signed [W-1:0] x, input logic signed [W-1:0] y,
    input logic signed [W-1:0] u, input logic signed [W-1:0] v
  );
    return DW'(x) * DW'(y) - DW'(u) * DW'(v);
  endfunction

  function automatic logic [MW-1:0] mag_dw(input logic signed [DW-1:0] v);
    logic [DW-1:0] u;
    u = v[DW-1] ? DW'(-v) : DW'(v);
    return u[MW-1:0];
  endfunction

  // global advance: move when the output register is free or taken
  logic adv;
  logic [NV-1:0] vld_r;
  logic          out_vld_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NV-2:0], in_ch.valid};
      out_vld_r <= vld_r[NV-1];
    end
  end

  // stage 1: pairwise determinants and cramer numerators
  logic signed [W-1:0]  s1_a1_r, s1_b1_r, s1_c1_r;
  logic signed [DW-1:0] s1_det_r [3];
  logic signed [DW-1:0] s1_num_r [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a1_r     <= in_ch.line1_a;
      s1_b1_r     <= in_ch.line1_b;
      s1_c1_r     <= in_ch.line1_c;
      s1_det_r[0] <= det2(in_ch.line1_a, in_ch.line2_b, in_ch.line1_b, in_ch.line2_a);
      s1_det_r[1] <= det2(in_ch.line1_a, in_ch.line3_b, in_ch.line1_b, in_ch.line3_a);
      s1_det_r[2] <= det2(in_ch.line2_a, in_ch.line3_b, in_ch.line2_b, in_ch.line3_a);
      s1_num_r[0] <= det2(in_ch.line1_c, in_ch.line2_b, in_ch.line1_b, in_ch.line2_c);
      s1_num_r[1] <= det2(in_ch.line1_a, in_ch.line2_c, in_ch.line1_c, in_ch.line2_a);
      s1_num_r[2] <= det2(in_ch.line1_c, in_ch.line3_b, in_ch.line1_b, in_ch.line3_c);
      s1_num_r[3] <= det2(in_ch.line1_a, in_ch.line3_c, in_ch.line1_c, in_ch.line3_a);
      s1_num_r[4] <= det2(in_ch.line2_c, in_ch.line3_b, in_ch.line2_b, in_ch.line3_c);
      s1_num_r[5] <= det2(in_ch.line2_a, in_ch.line3_c, in_ch.line2_c, in_ch.line3_a);
    end
  end

  // stage 2: cofactor products, magnitudes, divider operands
  logic signed [TW-1:0] s2_t1_r, s2_t2_r, s2_t3_r;
  logic [MW-1:0]        s2_mdet_r [3];
  logic [2:0]           s2_zero_r;
  logic [QP-1:0]        s2_pn_r  [6];
  logic [PDW-1:0]       s2_pd_r  [6];
  logic                 s2_psg_r [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_t1_r <= TW'(s1_a1_r) * TW'(s1_num_r[4]);
      s2_t2_r <= TW'(s1_b1_r) * TW'(s1_num_r[5]);
      s2_t3_r <= TW'(s1_c1_r) * TW'(s1_det_r[2]);
      for (int j = 0; j < 3; j++) begin
        s2_mdet_r[j] <= mag_dw(s1_det_r[j]);
        s2_zero_r[j] <= (s1_det_r[j] == '0);
      end
      for (int k = 0; k < 6; k++) begin
        s2_pn_r[k]  <= (QP'(mag_dw(s1_num_r[k])) << (PF + 1))
                     + QP'(mag_dw(s1_det_r[k / 2]));
        s2_pd_r[k]  <= PDW'(mag_dw(s1_det_r[k / 2])) << 1;
        s2_psg_r[k] <= s1_num_r[k][DW-1] ^ s1_det_r[k / 2][DW-1];
      end
    end
  end

  // stage 3: 3x3 determinant, triangle test, first product of magnitudes
  logic signed [D3W-1:0] d3;
  logic [D3W-1:0]        d3_mag;
  logic [M3W-1:0]        s3_m3_r;
  logic [PABW-1:0]       s3_pab_r;
  logic [MW-1:0]         s3_mbc_r;
  logic [3:0]            s3_flg_r;

  assign d3     = D3W'(s2_t3_r) - D3W'(s2_t1_r) - D3W'(s2_t2_r);
  assign d3_mag = d3[D3W-1] ? D3W'(-d3) : D3W'(d3);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_m3_r  <= d3_mag[M3W-1:0];
      s3_pab_r <= PABW'(s2_mdet_r[0]) * PABW'(s2_mdet_r[1]);
      s3_mbc_r <= s2_mdet_r[2];
      s3_flg_r <= {(s2_zero_r == 3'b000) && (d3 != '0), s2_zero_r};
    end
  end

  // stage 4: partial products of the square and of the denominator
  logic [2*H-1:0]   s4_ll_r;
  logic [H+HW-1:0]  s4_lh_r;
  logic [2*HW-1:0]  s4_hh_r;
  logic [2*MW-1:0]  s4_pl_r, s4_ph_r;
  logic [3:0]       s4_flg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ll_r  <= (2*H)'(s3_m3_r[H-1:0]) * (2*H)'(s3_m3_r[H-1:0]);
      s4_lh_r  <= (H+HW)'(s3_m3_r[H-1:0]) * (H+HW)'(s3_m3_r[M3W-1:H]);
      s4_hh_r  <= (2*HW)'(s3_m3_r[M3W-1:H]) * (2*HW)'(s3_m3_r[M3W-1:H]);
      s4_pl_r  <= (2*MW)'(s3_pab_r[MW-1:0]) * (2*MW)'(s3_mbc_r);
      s4_ph_r  <= (2*MW)'(s3_pab_r[PABW-1:MW]) * (2*MW)'(s3_mbc_r);
      s4_flg_r <= s3_flg_r;
    end
  end

  // stage 5: area numerator and denominator
  logic [NUMW-1:0]   sq;
  logic [NUMW-1:0]   s5_num_r;
  logic [DENA_W-1:0] s5_den_r;
  logic [3:0]        s5_flg_r;

  assign sq = (NUMW'(s4_hh_r) << (2 * H)) + (NUMW'(s4_lh_r) << (H + 1))
            + NUMW'(s4_ll_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_num_r <= sq << (AF + 1);
      s5_den_r <= (DENA_W'(s4_ph_r) << (MW + 1)) + (DENA_W'(s4_pl_r) << 1);
      s5_flg_r <= s4_flg_r;
    end
  end

  // stage 6: overflow check and divider start
  logic [NUMX-1:0]   numx;
  logic [NUMX-1:0]   num_hi;
  logic              ovf;
  logic [DENA_W-1:0] s6_rem_r;
  logic [QA-1:0]     s6_lo_r;
  logic [DENA_W-1:0] s6_den_r;
  logic [SA-1:0]     s6_side_r;

  assign numx   = NUMX'(s5_num_r);
  assign num_hi = numx >> QA;
  assign ovf    = num_hi >= NUMX'(s5_den_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_rem_r  <= ovf ? '0 : num_hi[DENA_W-1:0];
      s6_lo_r   <= numx[QA-1:0];
      s6_den_r  <= s5_den_r;
      s6_side_r <= {s5_flg_r, ovf};
    end
  end

  // area divider
  logic [QA-1:0] aq;
  logic [SA-1:0] aside;

  ltri_div #(
    .DEN_W  (DENA_W),
    .QUO_W  (QA),
    .SIDE_W (SA)
  ) u_area_div (
    .clk    (clk),
    .en     (adv),
    .rem_i  (s6_rem_r),
    .num_i  (s6_lo_r),
    .den_i  (s6_den_r),
    .side_i (s6_side_r),
    .quo_o  (aq),
    .side_o (aside)
  );

  // vertex dividers, sign fix, delay line to meet the area result
  logic [PNT_W-1:0] pnt_tail [6];

  for (genvar k = 0; k < 6; k++) begin : g_pnt
    logic [QP-1:0]    pq;
    logic             psg;
    logic [PNT_W-1:0] dl_r [L];

    ltri_div #(
      .DEN_W  (PDW),
      .QUO_W  (QP),
      .SIDE_W (1)
    ) u_pnt_div (
      .clk    (clk),
      .en     (adv),
      .rem_i  ('0),
      .num_i  (s2_pn_r[k]),
      .den_i  (s2_pd_r[k]),
      .side_i (s2_psg_r[k]),
      .quo_o  (pq),
      .side_o (psg)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        dl_r[0] <= psg ? PNT_W'(0) - PNT_W'(pq) : PNT_W'(pq);
        for (int j = 1; j < L; j++) begin
          dl_r[j] <= dl_r[j-1];
        end
      end
    end

    assign pnt_tail[k] = dl_r[L-1];
  end

  // output register: rounding, saturation, zeroing when no triangle
  logic [AREA_W-1:0] area_rnd;
  logic              tri_ok;
  logic [AREA_W-1:0] out_area_r;
  logic [3:0]        out_flg_r;
  logic [PNT_W-1:0]  out_pt_r [6];

  assign tri_ok   = aside[4];
  assign area_rnd = (aside[0] || (&aq)) ? AREA_MAX
                  : AREA_W'(aq >> 1) + AREA_W'(aq[0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_flg_r  <= aside[4:1];
      out_area_r <= tri_ok ? area_rnd : '0;
      for (int k = 0; k < 6; k++) begin
        out_pt_r[k] <= tri_ok ? pnt_tail[k] : '0;
      end
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.is_triangle = out_flg_r[3];
  assign out_ch.parallel_12 = out_flg_r[0];
  assign out_ch.parallel_13 = out_flg_r[1];
  assign out_ch.parallel_23 = out_flg_r[2];
  assign out_ch.p12_x       = out_pt_r[0];
  assign out_ch.p12_y       = out_pt_r[1];
  assign out_ch.p13_x       = out_pt_r[2];
  assign out_ch.p13_y       = out_pt_r[3];
  assign out_ch.p23_x       = out_pt_r[4];
  assign out_ch.p23_y       = out_pt_r[5];
  assign out_ch.tri_area    = out_area_r;

  // checks
  `LTRI_ASSERT_IMP(a_no_tri_zero, out_ch.valid && !out_ch.is_triangle,
    out_ch.tri_area == '0 && out_ch.p12_x == '0 && out_ch.p23_y == '0,
    "result word without a triangle carries nonzero data")
  `LTRI_ASSERT_IMP(a_tri_no_par, out_ch.valid && out_ch.is_triangle,
    !out_ch.parallel_12 && !out_ch.parallel_13 && !out_ch.parallel_23,
    "triangle flagged together with a parallel pair")
  `LTRI_ASSERT_NXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_r[0],
    "accepted word did not enter the pipeline")

endmodule
